// ===== rtl/imu_fpp_pkg.sv =====
// Shared types, constants and helper functions for the IMU FIFO packet parser.
`default_nettype none

package imu_fpp_pkg;

  localparam int unsigned PKT_MAX    = 20;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [CNT_W-1:0] cnt_t;

  // packet lengths in bytes
  localparam cnt_t LEN_HDR    = 5'd1;
  localparam cnt_t LEN_SINGLE = 5'd8;
  localparam cnt_t LEN_DUAL   = 5'd16;
  localparam cnt_t LEN_HIRES  = 5'd20;

  // header bit positions
  localparam int unsigned HDR_MSG_BIT   = 7;
  localparam int unsigned HDR_ACCEL_BIT = 6;
  localparam int unsigned HDR_GYRO_BIT  = 5;
  localparam int unsigned HDR_HIRES_BIT = 4;
  localparam int unsigned HDR_TS_BIT    = 3;

  // input operations
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // register map: index taken from paddr above the word offset
  localparam logic REG_DELTA_MODE = 1'b0;

  localparam logic [31:0] TS_WRAP_INC = 32'h0001_0000;

  typedef logic [PKT_MAX-1:0][7:0] pkt_bytes_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]         packet_header;
    logic signed [19:0] accel_x;
    logic signed [19:0] accel_y;
    logic signed [19:0] accel_z;
    logic signed [19:0] gyro_x;
    logic signed [19:0] gyro_y;
    logic signed [19:0] gyro_z;
    logic signed [15:0] temperature;
    logic               ts_present;
    logic [15:0]        timestamp_low;
    logic [31:0]        timestamp_full;
  } out_t;

  typedef struct packed {
    logic done;
    logic emit;
  } asm_stat_t;

  function automatic cnt_t pkt_len(input logic [7:0] hdr);
    cnt_t len;
    if (hdr[HDR_MSG_BIT]) begin
      len = LEN_HDR;
    end else if (hdr[HDR_ACCEL_BIT] && hdr[HDR_GYRO_BIT]) begin
      len = hdr[HDR_HIRES_BIT] ? LEN_HIRES : LEN_DUAL;
    end else if (hdr[HDR_ACCEL_BIT] || hdr[HDR_GYRO_BIT]) begin
      len = LEN_SINGLE;
    end else begin
      len = LEN_HDR;
    end
    return len;
  endfunction

  function automatic logic [15:0] be16(input pkt_bytes_t b, input int unsigned i);
    return {b[i], b[i+1]};
  endfunction

  function automatic logic signed [19:0] sx16(input logic [15:0] v);
    return {{4{v[15]}}, v};
  endfunction

  function automatic logic signed [15:0] sx8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/imu_fpp_assembler.sv =====
// Packet byte buffer and byte counter; flags the byte that completes a packet.
`default_nettype none

module imu_fpp_assembler (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   byte_valid,
  input  wire logic                   advance,
  input  wire logic                   flush,
  input  wire logic [7:0]             data_byte,
  output imu_fpp_pkg::pkt_bytes_t     pkt_bytes,
  output imu_fpp_pkg::asm_stat_t      stat
);

  logic [7:0]        buf_r [imu_fpp_pkg::PKT_MAX];
  imu_fpp_pkg::cnt_t cnt_r;
  imu_fpp_pkg::cnt_t cnt_nxt;
  imu_fpp_pkg::cnt_t cnt_inc;
  imu_fpp_pkg::cnt_t len;

  // the incoming byte overlays the slot it is about to fill
  always_comb begin
    for (int i = 0; i < imu_fpp_pkg::PKT_MAX; i++) begin
      pkt_bytes[i] = (cnt_r == imu_fpp_pkg::CNT_W'(i)) ? data_byte : buf_r[i];
    end
  end

  assign len       = imu_fpp_pkg::pkt_len(pkt_bytes[0]);
  assign cnt_inc   = cnt_r + 1'b1;
  assign stat.done = byte_valid && (cnt_inc == len);
  assign stat.emit = stat.done && (len != imu_fpp_pkg::LEN_HDR);

  always_comb begin
    cnt_nxt = cnt_r;
    if (flush) begin
      cnt_nxt = '0;
    end else if (byte_valid && advance) begin
      cnt_nxt = stat.done ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && advance) begin
      buf_r[cnt_r] <= data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imu_fpp_decode.sv =====
// Field extraction from a completed packet: axes, temperature and raw timestamp.
`default_nettype none

module imu_fpp_decode (
  input  wire imu_fpp_pkg::pkt_bytes_t pkt_bytes,
  output imu_fpp_pkg::out_t            fields
);

  logic [7:0]        hdr;
  imu_fpp_pkg::cnt_t len;

  assign hdr = pkt_bytes[0];
  assign len = imu_fpp_pkg::pkt_len(hdr);

  always_comb begin
    fields               = '0;
    fields.packet_header = hdr;
    unique case (len)
      imu_fpp_pkg::LEN_SINGLE: begin
        if (hdr[imu_fpp_pkg::HDR_ACCEL_BIT]) begin
          fields.accel_x = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 1));
          fields.accel_y = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 3));
          fields.accel_z = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 5));
        end else begin
          fields.gyro_x = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 1));
          fields.gyro_y = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 3));
          fields.gyro_z = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 5));
        end
        fields.temperature = imu_fpp_pkg::sx8(pkt_bytes[7]);
      end
      imu_fpp_pkg::LEN_DUAL: begin
        fields.accel_x     = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 1));
        fields.accel_y     = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 3));
        fields.accel_z     = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 5));
        fields.gyro_x      = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 7));
        fields.gyro_y      = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 9));
        fields.gyro_z      = imu_fpp_pkg::sx16(imu_fpp_pkg::be16(pkt_bytes, 11));
        fields.temperature = imu_fpp_pkg::sx8(pkt_bytes[13]);
        if (hdr[imu_fpp_pkg::HDR_TS_BIT]) begin
          fields.ts_present    = 1'b1;
          fields.timestamp_low = imu_fpp_pkg::be16(pkt_bytes, 14);
        end
      end
      imu_fpp_pkg::LEN_HIRES: begin
        // high nibble of each extension byte extends accel, low nibble gyro
        fields.accel_x = {imu_fpp_pkg::be16(pkt_bytes, 1),  pkt_bytes[17][7:4]};
        fields.accel_y = {imu_fpp_pkg::be16(pkt_bytes, 3),  pkt_bytes[18][7:4]};
        fields.accel_z = {imu_fpp_pkg::be16(pkt_bytes, 5),  pkt_bytes[19][7:4]};
        fields.gyro_x  = {imu_fpp_pkg::be16(pkt_bytes, 7),  pkt_bytes[17][3:0]};
        fields.gyro_y  = {imu_fpp_pkg::be16(pkt_bytes, 9),  pkt_bytes[18][3:0]};
        fields.gyro_z  = {imu_fpp_pkg::be16(pkt_bytes, 11), pkt_bytes[19][3:0]};
        fields.temperature = imu_fpp_pkg::be16(pkt_bytes, 13);
        if (hdr[imu_fpp_pkg::HDR_TS_BIT]) begin
          fields.ts_present    = 1'b1;
          fields.timestamp_low = imu_fpp_pkg::be16(pkt_bytes, 15);
        end
      end
      default: begin
        fields.packet_header = hdr;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/imu_fpp_tstamp.sv =====
// Timestamp extension: rollover unwrap in counter mode, running sum in delta mode.
`default_nettype none

module imu_fpp_tstamp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        flush,
  input  wire logic        update,
  input  wire logic        delta_mode,
  input  wire logic [15:0] ts_low,
  output logic      [31:0] ts_full
);

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [15:0] prev_r;
  logic [15:0] prev_nxt;
  logic        seen_r;
  logic [31:0] acc_base;

  assign acc_base = (seen_r && (ts_low < prev_r)) ? (acc_r + imu_fpp_pkg::TS_WRAP_INC) : acc_r;

  always_comb begin
    acc_nxt  = acc_r;
    prev_nxt = prev_r;
    if (!delta_mode) begin
      acc_nxt  = {acc_base[31:16], ts_low};
      prev_nxt = ts_low;
    end else if (!seen_r) begin
      acc_nxt  = {16'h0000, ts_low};
      prev_nxt = '0;
    end else begin
      acc_nxt  = acc_r + {16'h0000, ts_low};
      prev_nxt = ts_low;
    end
  end

  // value reported with the current packet
  assign ts_full = update ? acc_nxt : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      acc_r  <= '0;
      prev_r <= '0;
      seen_r <= 1'b0;
    end else if (update) begin
      acc_r  <= acc_nxt;
      prev_r <= prev_nxt;
      seen_r <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imu_fifo_packet_parser_top.sv =====
// A byte is registered on transfer; the result of a completing byte passes
// through the input stage, then the result register, before it appears on out_valid.
// Throughput: one byte per cycle; the input stage holds only while a finished
// result waits in a full output register that is not being taken.
// Reset (rst_n low, synchronous): byte count, timestamp state, delta mode and
// both valid flags clear; the packet byte buffer is not cleared.
`default_nettype none

module imu_fifo_packet_parser_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire imu_fpp_pkg::in_t                       in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output imu_fpp_pkg::out_t                           out_data,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [imu_fpp_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [imu_fpp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [imu_fpp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                        pready
);

  logic                    s1_valid_r;
  imu_fpp_pkg::in_t        s1_data_r;
  logic                    s1_adv;
  logic                    s1_byte;
  logic                    s1_flush;
  logic                    delta_mode_r;
  logic                    out_valid_r;
  imu_fpp_pkg::out_t       out_data_r;
  imu_fpp_pkg::out_t       out_data_nxt;
  imu_fpp_pkg::out_t       fields;
  imu_fpp_pkg::pkt_bytes_t pkt_bytes;
  imu_fpp_pkg::asm_stat_t  stat;
  logic                    ts_update;
  logic [31:0]             ts_full;
  logic                    reg_sel;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[imu_fpp_pkg::APB_ADDR_W-1] == imu_fpp_pkg::REG_DELTA_MODE);
  assign prdata  = reg_sel ? {{(imu_fpp_pkg::APB_DATA_W-1){1'b0}}, delta_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      delta_mode_r <= pwdata[0];
    end
  end

  // hold the input stage only when its result cannot enter the output register
  assign s1_adv   = !(s1_valid_r && stat.emit && out_valid_r && !out_ready);
  assign in_ready = s1_adv;
  assign s1_byte  = s1_valid_r && (s1_data_r.op == imu_fpp_pkg::OP_DATA);
  assign s1_flush = s1_valid_r && (s1_data_r.op == imu_fpp_pkg::OP_FLUSH) && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  imu_fpp_assembler u_assembler (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s1_byte),
    .advance    (s1_adv),
    .flush      (s1_flush),
    .data_byte  (s1_data_r.data_byte),
    .pkt_bytes  (pkt_bytes),
    .stat       (stat)
  );

  imu_fpp_decode u_decode (
    .pkt_bytes (pkt_bytes),
    .fields    (fields)
  );

  assign ts_update = stat.emit && s1_adv && fields.ts_present;

  imu_fpp_tstamp u_tstamp (
    .clk        (clk),
    .rst_n      (rst_n),
    .flush      (s1_flush),
    .update     (ts_update),
    .delta_mode (delta_mode_r),
    .ts_low     (fields.timestamp_low),
    .ts_full    (ts_full)
  );

  always_comb begin
    out_data_nxt                = fields;
    out_data_nxt.timestamp_full = ts_full;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.emit && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit && s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
